// File: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types for the fixed-point alu
// Transaction structs, action codes and the front-to-back item record.
// ----------------------------------------------------------------------------
package fpa_pkg;

  typedef enum logic [3:0] {
    ACT_ADD        = 4'd0,
    ACT_SUB        = 4'd1,
    ACT_MUL        = 4'd2,
    ACT_DIV        = 4'd3,
    ACT_MIN        = 4'd4,
    ACT_MAX        = 4'd5,
    ACT_INC        = 4'd6,
    ACT_DEC        = 4'd7,
    ACT_INT_TO_FIX = 4'd8,
    ACT_FIX_TO_INT = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               divide_by_zero;
  } out_item_t;

  // classified item handed from the front to the back
  typedef struct packed {
    kind_e       kind;
    logic [31:0] res;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
    logic        neg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
  } work_t;

endpackage

// File: rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: operand classification
// Computes compare flags, the simple-action results and operand magnitudes.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  fpa_pkg::in_item_t item_i,
  output fpa_pkg::work_t    work_o
);
  import fpa_pkg::*;

  logic signed [31:0] a, b;
  logic               b_lt_a;

  assign a      = item_i.operand_a;
  assign b      = item_i.operand_b;
  assign b_lt_a = b < a;

  always_comb begin
    work_o       = '0;
    work_o.kind  = KIND_SIMPLE;
    work_o.lt    = a < b;
    work_o.eq    = a == b;
    work_o.gt    = a > b;
    work_o.neg   = a[31] ^ b[31];
    work_o.mag_a = a[31] ? 32'(-a) : 32'(a);
    work_o.mag_b = b[31] ? 32'(-b) : 32'(b);
    unique case (action_e'(item_i.action))
      ACT_ADD:        work_o.res = 32'(a + b);
      ACT_SUB:        work_o.res = 32'(a - b);
      ACT_MUL:        work_o.kind = KIND_MUL;
      ACT_DIV: begin
        work_o.kind = KIND_DIV;
        work_o.dz   = (b == 32'sd0);
      end
      ACT_MIN:        work_o.res = b_lt_a ? b : a;
      ACT_MAX:        work_o.res = b_lt_a ? a : b;
      ACT_INC:        work_o.res = 32'(a + 32'sd1);
      ACT_DEC:        work_o.res = 32'(a - 32'sd1);
      ACT_INT_TO_FIX: work_o.res = a << FRAC_BITS;
      ACT_FIX_TO_INT: work_o.res = a >>> FRAC_BITS;
      default:        work_o.res = '0;
    endcase
  end

endmodule

// File: rtl/fpa_queue.sv
// ----------------------------------------------------------------------------
// fpa_queue: two-entry item queue
// Decouples the front from the back pipeline.
// ----------------------------------------------------------------------------
module fpa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpa_pkg::work_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fpa_pkg::work_t pop_data_o
);
  import fpa_pkg::*;

  work_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

// File: rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back: execution pipeline
// Multiplier stage, one restoring-division stage per quotient bit, output reg.
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  fpa_pkg::work_t    work_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fpa_pkg::out_item_t out_data_o
);
  import fpa_pkg::*;

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  typedef struct packed {
    kind_e            kind;
    logic [31:0]      res;
    logic             lt;
    logic             eq;
    logic             gt;
    logic             dz;
    logic             neg;
    logic [31:0]      den;
    logic [31:0]      rem;
    logic [NUM_W-1:0] quo;
  } stage_t;

  logic        adv;
  logic        s0_vld_q;
  stage_t      s0_q;
  logic [63:0] prod_q;
  logic        vld_q [NUM_W];
  stage_t      stg_q [NUM_W];
  stage_t      stg_d [NUM_W];
  out_item_t   out_q, out_d;
  logic        out_vld_q;

  // the whole pipeline holds while a finished result is stalled
  assign adv         = !(out_vld_q && out_stall_i);
  assign pop_o       = adv && !empty_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q.kind <= work_i.kind;
      s0_q.res  <= work_i.res;
      s0_q.lt   <= work_i.lt;
      s0_q.eq   <= work_i.eq;
      s0_q.gt   <= work_i.gt;
      s0_q.dz   <= work_i.dz;
      s0_q.neg  <= work_i.neg;
      s0_q.den  <= work_i.mag_b;
      s0_q.rem  <= '0;
      s0_q.quo  <= {work_i.mag_a, {FRAC_BITS{1'b0}}};
      prod_q    <= work_i.mag_a * work_i.mag_b;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    stage_t      prev;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    logic [63:0] rnd;
    logic [31:0] mres;

    if (k == 0) begin : g_first
      assign prev = s0_q;
    end else begin : g_next
      assign prev = stg_q[k-1];
    end

    assign trial = {prev.rem, prev.quo[NUM_W-1]};
    assign diff  = trial - {1'b0, prev.den};
    assign ge    = trial >= {1'b0, prev.den};
    assign rnd   = (prod_q + HALF) >> FRAC_BITS;
    assign mres  = prev.neg ? 32'(-rnd[31:0]) : rnd[31:0];

    always_comb begin
      stg_d[k]     = prev;
      stg_d[k].rem = ge ? diff[31:0] : trial[31:0];
      stg_d[k].quo = {prev.quo[NUM_W-2:0], ge};
      // product rounding rides on the first division stage
      if (k == 0 && prev.kind == KIND_MUL) stg_d[k].res = mres;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= (k == 0) ? s0_vld_q : vld_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) stg_q[k] <= stg_d[k];
    end
  end

  stage_t      last;
  logic        rup;
  logic [31:0] qr;

  assign last = stg_q[NUM_W-1];
  assign rup  = {last.rem, 1'b0} >= {1'b0, last.den};
  assign qr   = last.quo[31:0] + 32'(rup);

  always_comb begin
    out_d.a_less         = last.lt;
    out_d.a_equal        = last.eq;
    out_d.a_greater      = last.gt;
    out_d.divide_by_zero = last.dz;
    if (last.kind == KIND_DIV) begin
      out_d.result_value = last.dz ? 32'sd0 : (last.neg ? 32'(-qr) : qr);
    end else begin
      out_d.result_value = last.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[NUM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

endmodule

// File: rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu: signed 32-bit fixed-point alu
// Add, subtract, rounded multiply and divide, min, max, inc, dec and shifts.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-----------------------
//  in        | input     | in_valid_i/in_stall_o  | fpa_pkg::in_item_t
//  out       | output    | out_valid_o/out_stall_i| fpa_pkg::out_item_t
//
//  one transaction per cycle sustained while out_stall_i is low; the division
//  pipeline resolves one quotient bit per stage
//  reset clears the queue and all pipeline valid bits, payload is unreset
//  an output stall freezes the back pipeline; the two-entry queue keeps
//  taking input transactions until it fills
// ----------------------------------------------------------------------------
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fpa_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fpa_pkg::out_item_t out_data_o
);
  import fpa_pkg::*;

  work_t work_front, work_back;
  logic  q_full, q_empty, q_pop, q_push;

  // classification is combinational on the accepted transaction
  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .item_i (in_data_i),
    .work_o (work_front)
  );

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  // queue between front and back
  fpa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (work_front),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (work_back)
  );

  // multiplier and pipelined divider
  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .work_i      (work_back),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
